FILE: rtl/core/t1br_pkg.sv
// Shared types, constants and helpers for the T=1 block receiver.
// Used by t1br_parse, t1br_emit and the top level; depends on nothing.
package t1br_pkg;

   // Packet limits and counter widths
   localparam int MaxPacket = 64;
   localparam int CountW    = $clog2(MaxPacket + 2);
   localparam int CmpW      = (CountW > 8) ? CountW : 8;
   localparam int MinPacket = 7;
   localparam int HdrLen    = 3;

   // Byte positions inside a packet
   localparam int PosHdr0     = 0;
   localparam int PosLen      = 1;
   localparam int PosHdr2     = 2;
   localparam int PosNad      = 3;
   localparam int PosPcb      = 4;
   localparam int PosInfLen   = 5;
   localparam int PosFirstInf = 6;

   // Result item kinds
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_VERDICT = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;

   // Verdict codes
   localparam logic [2:0] VERD_OK        = 3'd0;
   localparam logic [2:0] VERD_SHORT     = 3'd1;
   localparam logic [2:0] VERD_BAD_HDR   = 3'd2;
   localparam logic [2:0] VERD_BAD_LRC   = 3'd3;
   localparam logic [2:0] VERD_OVERLONG  = 3'd4;

   // Block types
   localparam logic [1:0] BTYPE_I = 2'd0;
   localparam logic [1:0] BTYPE_R = 2'd1;
   localparam logic [1:0] BTYPE_S = 2'd2;

   // PCB codes and reply bytes
   localparam logic [7:0] PCB_TYPE_MASK = 8'hC0;
   localparam logic [7:0] PCB_R_CODE    = 8'h80;
   localparam logic [7:0] PCB_WTX       = 8'hC3;
   localparam logic [7:0] PCB_KEY_A     = 8'hC4;
   localparam logic [7:0] PCB_KEY_B     = 8'hF4;
   localparam logic [7:0] PCB_CARD_A    = 8'hE5;
   localparam logic [7:0] PCB_CARD_B    = 8'hF5;
   localparam logic [7:0] RSP_WTX_PCB   = 8'hE3;
   localparam logic [7:0] RSP_CARD_PCB  = 8'hD5;
   localparam logic [7:0] RSP_KEY_NAD   = 8'hE2;
   localparam logic [7:0] RSP_KEY_PCB   = 8'hE4;
   localparam logic [7:0] FRAME_LEN_SHORT = 8'd4;
   localparam logic [7:0] FRAME_LEN_LONG  = 8'd5;

   // Emit sequence slots
   localparam logic [3:0] SLOT_DATA    = 4'd0;
   localparam logic [3:0] SLOT_VERDICT = 4'd1;
   localparam logic [3:0] SLOT_HDR0    = 4'd2;
   localparam logic [3:0] SLOT_HLEN    = 4'd3;
   localparam logic [3:0] SLOT_HDR2    = 4'd4;
   localparam logic [3:0] SLOT_BLK0    = 4'd5;
   localparam logic [3:0] SLOT_BLK1    = 4'd6;
   localparam logic [3:0] SLOT_BLK2    = 4'd7;
   localparam logic [3:0] SLOT_BLK3    = 4'd8;
   localparam logic [3:0] SLOT_LRC     = 4'd9;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_word_type;

   typedef struct packed {
      logic [1:0] item_kind;
      logic [7:0] byte_value;
      logic [2:0] verdict;
      logic [1:0] block_type;
      logic [7:0] control_byte;
      logic       seq_bit;
      logic       reply_sent;
      logic       run_last;
   } rsp_word_type;

   // Everything one input byte causes, handed from parser to emitter
   typedef struct packed {
      logic       has_data;
      logic [7:0] data;
      logic       has_verdict;
      logic [2:0] verdict;
      logic [1:0] block_type;
      logic [7:0] control_byte;
      logic       seq_bit;
      logic       reply;
      logic       long_reply;
      logic [7:0] blk0;
      logic [7:0] blk1;
      logic [7:0] blk2;
      logic [7:0] blk3;
      logic [7:0] lrc;
   } bundle_type;

   // Swap the source and destination nibbles of a NAD
   function automatic logic [7:0] mirror_nad(input logic [7:0] nad);
      return {nad[3:0], nad[7:4]};
   endfunction

endpackage

FILE: rtl/core/t1br_parse.sv
// Input register and per-byte packet parser of the T=1 block receiver.
// Depends on t1br_pkg; feeds t1br_emit one bundle for each byte that has results.
module t1br_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  t1br_pkg::req_word_type req_word,
   output logic                  bnd_valid,
   output t1br_pkg::bundle_type  bnd_word,
   input  logic                  bnd_stall
);
   import t1br_pkg::*;

   logic               in_valid_ff;
   req_word_type       in_ff;
   logic [CountW-1:0]  byte_count_ff, byte_count_in;
   logic               header_ok_ff, header_ok_in;
   logic [7:0]         length_ff, length_in;
   logic [7:0]         xor_ff, xor_in;
   logic [7:0]         nad_ff, nad_in;
   logic [7:0]         pcb_ff, pcb_in;
   logic [7:0]         inf_len_ff, inf_len_in;
   logic [7:0]         first_inf_ff, first_inf_in;
   logic               seq_ff, seq_in;

   logic [CountW-1:0]  pos, n_cnt;
   logic [CmpW-1:0]    n_cmp;
   logic               in_window, has_items, take;
   logic [2:0]         verd;
   logic [1:0]         btype;
   logic               seq_out, reply, long_reply, card;
   logic [7:0]         blk0, blk1, blk2, blk3;

   // Handshake: a word leaves the input register when its results fit
   assign has_items = in_window && (pos >= CountW'(PosNad)) || in_ff.rx_last;
   assign take      = in_valid_ff && (!has_items || !bnd_stall);
   assign req_stall = in_valid_ff && !take;
   assign bnd_valid = in_valid_ff && has_items;

   // Hold the input word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_ff <= req_word;
      end
   end

   // Advance the packet state for this byte
   always_comb begin
      pos          = byte_count_ff;
      in_window    = pos < CountW'(MaxPacket);
      n_cnt        = (pos <= CountW'(MaxPacket)) ? pos + CountW'(1) : pos;
      n_cmp        = CmpW'(n_cnt);
      header_ok_in = header_ok_ff;
      length_in    = length_ff;
      xor_in       = xor_ff;
      nad_in       = nad_ff;
      pcb_in       = pcb_ff;
      inf_len_in   = inf_len_ff;
      first_inf_in = first_inf_ff;
      if (in_window) begin
         if (pos == CountW'(PosHdr0) || pos == CountW'(PosHdr2)) begin
            if (in_ff.rx_byte != 8'd0) header_ok_in = 1'b0;
         end else if (pos == CountW'(PosLen)) begin
            length_in = in_ff.rx_byte;
         end else begin
            xor_in = xor_ff ^ in_ff.rx_byte;
            if (pos == CountW'(PosNad))      nad_in       = in_ff.rx_byte;
            if (pos == CountW'(PosPcb))      pcb_in       = in_ff.rx_byte;
            if (pos == CountW'(PosInfLen))   inf_len_in   = in_ff.rx_byte;
            if (pos == CountW'(PosFirstInf)) first_inf_in = in_ff.rx_byte;
         end
      end
   end

   // Judge the packet and build the reply block
   always_comb begin
      if (!pcb_in[7]) begin
         btype = BTYPE_I;
      end else if ((pcb_in & PCB_TYPE_MASK) == PCB_R_CODE) begin
         btype = BTYPE_R;
      end else begin
         btype = BTYPE_S;
      end

      if (n_cmp < CmpW'(MinPacket)) begin
         verd = VERD_SHORT;
      end else if (n_cmp > CmpW'(MaxPacket)) begin
         verd = VERD_OVERLONG;
      end else if (!header_ok_in || CmpW'(length_in) != n_cmp - CmpW'(HdrLen)) begin
         verd = VERD_BAD_HDR;
      end else if (xor_in != 8'd0) begin
         verd = VERD_BAD_LRC;
      end else begin
         verd = VERD_OK;
      end

      seq_out    = seq_ff;
      reply      = 1'b0;
      long_reply = 1'b0;
      card       = 1'b0;
      blk0       = mirror_nad(nad_in);
      blk1       = RSP_WTX_PCB;
      blk2       = 8'd0;
      blk3       = first_inf_in;
      if (verd == VERD_OK) begin
         if (btype == BTYPE_R) begin
            seq_out = pcb_in[4];
         end else if (btype == BTYPE_I) begin
            seq_out = ~seq_ff;
         end
         if (pcb_in == PCB_WTX) begin
            reply = 1'b1;
            if (inf_len_in != 8'd0) begin
               long_reply = 1'b1;
               blk2       = 8'd1;
            end
         end else if (pcb_in == PCB_KEY_A || pcb_in == PCB_KEY_B) begin
            reply = 1'b1;
            blk0  = RSP_KEY_NAD;
            blk1  = RSP_KEY_PCB | {1'b0, seq_out, 6'd0};
         end else if (pcb_in == PCB_CARD_A || pcb_in == PCB_CARD_B) begin
            reply = 1'b1;
            card  = 1'b1;
            blk1  = RSP_CARD_PCB;
         end
         if (card) seq_out = 1'b0;
      end
   end

   // Pack the results of this byte
   always_comb begin
      bnd_word              = '0;
      bnd_word.has_data     = in_window && (pos >= CountW'(PosNad));
      bnd_word.data         = in_ff.rx_byte;
      bnd_word.has_verdict  = in_ff.rx_last;
      bnd_word.verdict      = verd;
      bnd_word.block_type   = btype;
      bnd_word.control_byte = pcb_in;
      bnd_word.seq_bit      = seq_out;
      bnd_word.reply        = reply;
      bnd_word.long_reply   = long_reply;
      bnd_word.blk0         = blk0;
      bnd_word.blk1         = blk1;
      bnd_word.blk2         = blk2;
      bnd_word.blk3         = blk3;
      bnd_word.lrc          = blk0 ^ blk1 ^ blk2 ^ (long_reply ? blk3 : 8'd0);
   end

   // Clear the packet state after the last byte
   assign byte_count_in = in_ff.rx_last ? '0 : n_cnt;
   assign seq_in        = in_ff.rx_last ? seq_out : seq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         header_ok_ff  <= 1'b1;
         length_ff     <= 8'd0;
         xor_ff        <= 8'd0;
         nad_ff        <= 8'd0;
         pcb_ff        <= 8'd0;
         inf_len_ff    <= 8'd0;
         first_inf_ff  <= 8'd0;
         seq_ff        <= 1'b0;
      end else if (take) begin
         byte_count_ff <= byte_count_in;
         seq_ff        <= seq_in;
         if (in_ff.rx_last) begin
            header_ok_ff <= 1'b1;
            length_ff    <= 8'd0;
            xor_ff       <= 8'd0;
            nad_ff       <= 8'd0;
            pcb_ff       <= 8'd0;
            inf_len_ff   <= 8'd0;
            first_inf_ff <= 8'd0;
         end else begin
            header_ok_ff <= header_ok_in;
            length_ff    <= length_in;
            xor_ff       <= xor_in;
            nad_ff       <= nad_in;
            pcb_ff       <= pcb_in;
            inf_len_ff   <= inf_len_in;
            first_inf_ff <= first_inf_in;
         end
      end
   end

`ifndef SYNTH
   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      take && in_ff.rx_last |=> byte_count_ff == '0)
      else $error("byte count not cleared after packet end");
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CountW'(MaxPacket + 1))
      else $error("byte count beyond saturation");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_ff))
      else $error("stalled input word changed");
`endif

endmodule

FILE: rtl/core/t1br_emit.sv
// Bundle register, item sequencer and result register of the receiver.
// Depends on t1br_pkg; takes bundles from t1br_parse.
module t1br_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  bnd_valid,
   input  t1br_pkg::bundle_type  bnd_word,
   output logic                  bnd_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output t1br_pkg::rsp_word_type rsp_word
);
   import t1br_pkg::*;

   logic          bnd_valid_ff;
   bundle_type    bnd_ff;
   logic          mid_ff;
   logic [3:0]    slot_ff;
   logic          rsp_valid_ff;
   rsp_word_type  rsp_ff;

   logic          out_load, emit, is_final, done;
   logic [3:0]    slot;
   rsp_word_type  item;

   // Pick the current slot and see whether it closes the bundle
   always_comb begin
      slot = mid_ff ? slot_ff : (bnd_ff.has_data ? SLOT_DATA : SLOT_VERDICT);
      case (slot)
         SLOT_DATA:    is_final = !bnd_ff.has_verdict;
         SLOT_VERDICT: is_final = !bnd_ff.reply;
         SLOT_BLK3:    is_final = !bnd_ff.long_reply;
         SLOT_LRC:     is_final = 1'b1;
         default:      is_final = 1'b0;
      endcase
   end

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = bnd_valid_ff && out_load;
   assign done      = emit && is_final;
   assign bnd_stall = bnd_valid_ff && !done;

   // Build the item for the current slot
   always_comb begin
      item          = '0;
      item.run_last = is_final;
      case (slot)
         SLOT_DATA: begin
            item.item_kind  = KIND_DATA;
            item.byte_value = bnd_ff.data;
         end
         SLOT_VERDICT: begin
            item.item_kind    = KIND_VERDICT;
            item.verdict      = bnd_ff.verdict;
            item.block_type   = bnd_ff.block_type;
            item.control_byte = bnd_ff.control_byte;
            item.seq_bit      = bnd_ff.seq_bit;
            item.reply_sent   = bnd_ff.reply;
         end
         SLOT_HDR0: item.item_kind = KIND_REPLY;
         SLOT_HLEN: begin
            item.item_kind  = KIND_REPLY;
            item.byte_value = bnd_ff.long_reply ? FRAME_LEN_LONG : FRAME_LEN_SHORT;
         end
         SLOT_HDR2: item.item_kind = KIND_REPLY;
         SLOT_BLK0: begin
            item.item_kind  = KIND_REPLY;
            item.byte_value = bnd_ff.blk0;
         end
         SLOT_BLK1: begin
            item.item_kind  = KIND_REPLY;
            item.byte_value = bnd_ff.blk1;
         end
         SLOT_BLK2: begin
            item.item_kind  = KIND_REPLY;
            item.byte_value = bnd_ff.blk2;
         end
         SLOT_BLK3: begin
            item.item_kind  = KIND_REPLY;
            item.byte_value = bnd_ff.long_reply ? bnd_ff.blk3 : bnd_ff.lrc;
         end
         SLOT_LRC: begin
            item.item_kind  = KIND_REPLY;
            item.byte_value = bnd_ff.lrc;
         end
         default: item = '0;
      endcase
   end

   // Hold the bundle until its last item is out
   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
      end else if (!bnd_stall) begin
         bnd_valid_ff <= bnd_valid;
      end
      if (bnd_valid && !bnd_stall) begin
         bnd_ff <= bnd_word;
      end
   end

   // Advance the slot sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff  <= 1'b0;
         slot_ff <= SLOT_DATA;
      end else if (emit) begin
         mid_ff  <= !is_final;
         slot_ff <= slot + 4'd1;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= bnd_valid_ff;
      end
      if (emit) begin
         rsp_ff <= item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTH
   a_mid_has_bundle: assert property (@(posedge clock) disable iff (reset)
      mid_ff |-> bnd_valid_ff)
      else $error("sequencer mid-bundle without a bundle");
   a_frame_needs_reply: assert property (@(posedge clock) disable iff (reset)
      mid_ff && slot_ff >= SLOT_HDR0 |-> bnd_ff.reply)
      else $error("reply frame slot without a reply");
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.item_kind == KIND_VERDICT |->
         rsp_ff.run_last == !rsp_ff.reply_sent)
      else $error("verdict end marker disagrees with reply flag");
`endif

endmodule

FILE: rtl/core/t1_block_receiver_with_auto_reply_top.sv
// T=1 block receiver with automatic S-block replies, top level.
// Depends on t1br_pkg, t1br_parse and t1br_emit.
//
// Usage:
//   req_* carries one received packet word per handshake: rx_byte and
//   rx_last, which marks the final byte of the packet (header included).
//   rsp_* carries result words: a data word for every block byte within
//   the size limit, a verdict word after the last byte, and on a good WTX, key-press or
//   card-presence S-block the 7- or 8-word reply frame. run_last marks
//   the final result word caused by one request word.
// Path: the first result of a request word passes the input register,
//   the bundle register and the result register.
// Throughput: one request word per cycle while each causes at most one
//   result and rsp_stall is low; at a packet end the single result register
//   drains up to nine extra result words from the bundle one by one.
// Reset: synchronous; clears packet state and the sequence bit, and
//   drops all words in flight. No clearing pass is needed.
// Stall: rsp_stall holds the result word; the bundle and input
//   registers then fill and req_stall rises, no word is lost.
module t1_block_receiver_with_auto_reply_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  t1br_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output t1br_pkg::rsp_word_type  rsp_word
);
   import t1br_pkg::*;

   logic       bnd_valid;
   logic       bnd_stall;
   bundle_type bnd_word;

   // Parse each byte into a bundle of results
   t1br_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .bnd_valid (bnd_valid),
      .bnd_word  (bnd_word),
      .bnd_stall (bnd_stall)
   );

   // Serialize bundles into result words
   t1br_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .bnd_valid (bnd_valid),
      .bnd_word  (bnd_word),
      .bnd_stall (bnd_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: bench/tb_t1_block_receiver_with_auto_reply_top.sv
// Self-checking bench for the T=1 block receiver with automatic replies.
// Drives whole packets (good, broken, short, overlong, noise) through the
// block and checks every result word; depends on t1br_pkg and the block.
`timescale 1ns / 100ps

module tb_t1_block_receiver_with_auto_reply_top;
   import t1br_pkg::*;

   // Tracks packet state and holds the result words still to come
   class block_verdict_board;
      rsp_word_type expected_words[$];
      int           errors;
      int unsigned  byte_count;
      logic         header_ok;
      logic [7:0]   length_field;
      logic [7:0]   running_xor;
      logic [7:0]   node_address;
      logic [7:0]   pcb_byte;
      logic [7:0]   info_length;
      logic [7:0]   first_info;
      logic         seq_state;

      function new();
         clear_packet();
         seq_state = 1'b0;
         errors = 0;
      endfunction

      function void clear_packet();
         byte_count = 0;
         header_ok = 1'b1;
         length_field = 8'h00;
         running_xor = 8'h00;
         node_address = 8'h00;
         pcb_byte = 8'h00;
         info_length = 8'h00;
         first_info = 8'h00;
      endfunction

      function rsp_word_type reply_word(logic [7:0] value);
         rsp_word_type w;
         w = '0;
         w.item_kind = KIND_REPLY;
         w.byte_value = value;
         return w;
      endfunction

      // Work out every result word caused by one accepted byte
      function void absorb_byte(logic [7:0] b, logic last);
         rsp_word_type run[$];
         rsp_word_type w;
         logic [7:0]   blk[4];
         logic [7:0]   lrc;
         int           blen;
         int unsigned  pos;
         pos = byte_count;
         blen = 0;
         if (byte_count <= MaxPacket) byte_count++;

         // Bytes past the size limit enter no check and make no data word
         if (pos < MaxPacket) begin
            if (pos == PosHdr0 || pos == PosHdr2) begin
               if (b != 8'h00) header_ok = 1'b0;
            end else if (pos == PosLen) begin
               length_field = b;
            end else begin
               running_xor ^= b;
               case (pos)
                  PosNad:      node_address = b;
                  PosPcb:      pcb_byte = b;
                  PosInfLen:   info_length = b;
                  PosFirstInf: first_info = b;
                  default:     ;
               endcase
               w = '0;
               w.item_kind = KIND_DATA;
               w.byte_value = b;
               run.push_back(w);
            end
         end

         if (last) begin
            w = '0;
            w.item_kind = KIND_VERDICT;
            w.control_byte = pcb_byte;
            if (!pcb_byte[7]) begin
               w.block_type = BTYPE_I;
            end else if ((pcb_byte & PCB_TYPE_MASK) == PCB_R_CODE) begin
               w.block_type = BTYPE_R;
            end else begin
               w.block_type = BTYPE_S;
            end

            if (byte_count < MinPacket) begin
               w.verdict = VERD_SHORT;
            end else if (byte_count > MaxPacket) begin
               w.verdict = VERD_OVERLONG;
            end else if (!header_ok || int'(length_field) != int'(byte_count) - HdrLen) begin
               w.verdict = VERD_BAD_HDR;
            end else if (running_xor != 8'h00) begin
               w.verdict = VERD_BAD_LRC;
            end else begin
               w.verdict = VERD_OK;
            end

            // Good block: advance the sequence bit and pick the reply
            if (w.verdict == VERD_OK) begin
               if (w.block_type == BTYPE_R) seq_state = pcb_byte[4];
               else if (w.block_type == BTYPE_I) seq_state = ~seq_state;

               if (pcb_byte == PCB_WTX) begin
                  blk[0] = {node_address[3:0], node_address[7:4]};
                  blk[1] = RSP_WTX_PCB;
                  if (info_length == 8'h00) begin
                     blk[2] = 8'h00;
                     blen = 3;
                  end else begin
                     blk[2] = 8'h01;
                     blk[3] = first_info;
                     blen = 4;
                  end
               end else if (pcb_byte == PCB_KEY_A || pcb_byte == PCB_KEY_B) begin
                  blk[0] = RSP_KEY_NAD;
                  blk[1] = RSP_KEY_PCB | {1'b0, seq_state, 6'b0};
                  blk[2] = 8'h00;
                  blen = 3;
               end else if (pcb_byte == PCB_CARD_A || pcb_byte == PCB_CARD_B) begin
                  blk[0] = {node_address[3:0], node_address[7:4]};
                  blk[1] = RSP_CARD_PCB;
                  blk[2] = 8'h00;
                  blen = 3;
                  seq_state = 1'b0;
               end
            end

            w.seq_bit = seq_state;
            w.reply_sent = (blen != 0);
            run.push_back(w);

            // Reply frame: header, block, then XOR of the block
            if (blen != 0) begin
               lrc = 8'h00;
               run.push_back(reply_word(8'h00));
               run.push_back(reply_word(8'(blen + 1)));
               run.push_back(reply_word(8'h00));
               for (int i = 0; i < blen; i++) begin
                  run.push_back(reply_word(blk[i]));
                  lrc ^= blk[i];
               end
               run.push_back(reply_word(lrc));
            end
            clear_packet();
         end

         if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
         foreach (run[i]) expected_words.push_back(run[i]);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one result word with the oldest expectation
      function void compare_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            $error("result word 0x%0h arrived with nothing expected", got);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         check_field("item_kind", want.item_kind, got.item_kind);
         check_field("byte_value", want.byte_value, got.byte_value);
         check_field("verdict", want.verdict, got.verdict);
         check_field("block_type", want.block_type, got.block_type);
         check_field("control_byte", want.control_byte, got.control_byte);
         check_field("seq_bit", want.seq_bit, got.seq_bit);
         check_field("reply_sent", want.reply_sent, got.reply_sent);
         check_field("run_last", want.run_last, got.run_last);
      endfunction
   endclass

   localparam int TotalWords = 500;
   localparam int PhaseLen   = 165;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   block_verdict_board board;
   logic [7:0]         pkt[$];
   int                 words_sent = 0;
   int                 req_idle_pct = 28;
   int                 rsp_stall_pct = 45;

   t1_block_receiver_with_auto_reply_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result side at the current phase's rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.compare_word(rsp_word);
   end

   // Offer one word, with random gaps, and hold it until accepted
   task automatic send_word(logic [7:0] b, logic last);
      req_word_type w;
      if (words_sent < PhaseLen) begin
         req_idle_pct = 28;
         rsp_stall_pct = 45;
      end else if (words_sent < 2 * PhaseLen) begin
         req_idle_pct = 45;
         rsp_stall_pct = 28;
      end else begin
         req_idle_pct = 0;
         rsp_stall_pct = 0;
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      w.rx_byte = b;
      w.rx_last = last;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.absorb_byte(b, last);
      words_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
   endtask

   // Build a well-formed packet with random info bytes and a correct LRC
   task automatic load_block(logic [7:0] nad, logic [7:0] pcb, int ninfo,
                             logic [7:0] len_byte);
      logic [7:0] lrc;
      pkt.delete();
      pkt.push_back(8'h00);
      pkt.push_back(8'(ninfo + 4));
      pkt.push_back(8'h00);
      pkt.push_back(nad);
      pkt.push_back(pcb);
      pkt.push_back(len_byte);
      repeat (ninfo) pkt.push_back(8'($urandom));
      lrc = 8'h00;
      for (int i = PosNad; i < pkt.size(); i++) lrc ^= pkt[i];
      pkt.push_back(lrc);
   endtask

   task automatic load_noise(int n);
      pkt.delete();
      repeat (n) pkt.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
   endtask

   // One random packet: mostly good blocks, some broken, short, overlong or noise
   task automatic random_packet();
      int         pick;
      int         ninfo;
      logic [7:0] pcb;
      pick = $urandom_range(99);
      case ($urandom_range(5))
         0:       pcb = {1'b0, 7'($urandom)};
         1:       pcb = {2'b10, 6'($urandom)};
         2:       pcb = PCB_WTX;
         3:       pcb = $urandom_range(1) ? PCB_KEY_A : PCB_KEY_B;
         4:       pcb = $urandom_range(1) ? PCB_CARD_A : PCB_CARD_B;
         default: pcb = {2'b11, 6'($urandom)};
      endcase
      ninfo = ($urandom_range(9) == 0) ? $urandom_range(MaxPacket - 7) : $urandom_range(3);

      if (pick < 60) begin
         load_block(8'($urandom), pcb, ninfo,
                    ($urandom_range(9) == 0) ? 8'($urandom) : 8'(ninfo));
      end else if (pick < 75) begin
         load_block(8'($urandom), pcb, ninfo, 8'(ninfo));
         case ($urandom_range(3))
            0:       pkt[PosHdr0] = 8'($urandom_range(255, 1));
            1:       pkt[PosHdr2] = 8'($urandom_range(255, 1));
            2:       pkt[PosLen] ^= 8'($urandom_range(255, 1));
            default: pkt[pkt.size() - 1] ^= 8'($urandom_range(255, 1));
         endcase
      end else if (pick < 85) begin
         load_noise($urandom_range(MinPacket - 1, 1));
      end else if (pick < 90) begin
         ninfo = MaxPacket - 6 + $urandom_range(10);
         load_block(8'($urandom), pcb, ninfo, 8'(ninfo));
      end else begin
         load_noise($urandom_range(20, 1));
      end
      send_packet();
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: smallest I-block, R-block with bit 4 set, WTX with info,
      // key press after a sequence change, card presence, one-byte packet
      load_block(8'h00, 8'h00, 0, 8'h00);
      send_packet();
      load_block(8'hFF, 8'h90, 0, 8'h00);
      send_packet();
      load_block(8'h12, PCB_WTX, 1, 8'h01);
      send_packet();
      load_block(8'h21, PCB_KEY_B, 0, 8'h00);
      send_packet();
      load_block(8'h5A, PCB_CARD_A, 0, 8'h00);
      send_packet();
      pkt.delete();
      pkt.push_back(8'hFF);
      send_packet();

      while (words_sent < TotalWords) random_packet();
      req_valid <= 1'b0;

      // Drain, then wait for anything unexpected
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb_t1_block_receiver_with_auto_reply_top passed");
      end else begin
         $display("tb_t1_block_receiver_with_auto_reply_top failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("tb_t1_block_receiver_with_auto_reply_top failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/t1br_pkg.sv
rtl/core/t1br_parse.sv
rtl/core/t1br_emit.sv
rtl/core/t1_block_receiver_with_auto_reply_top.sv
bench/tb_t1_block_receiver_with_auto_reply_top.sv
